// ----- sv/lph_pkg.sv -----
package lph_pkg;

  // Fixed field widths and build-time table settings
  localparam int SAMPLE_RATE       = 48000;
  localparam int COEFF_TABLE_DEPTH = 256;
  localparam int COEFF_IDX_W       = $clog2(COEFF_TABLE_DEPTH);
  localparam int PHASE_W           = 24;
  localparam int SAMPLE_W          = 16;
  localparam int COEFF_W           = 16;
  localparam int MEM_W             = 20;
  localparam int STEP_W            = 16;
  localparam int PROD_W            = COEFF_W + MEM_W;

  localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 16'd350;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;      // latch the accepted transaction and look up its coefficient
    logic mem_rd;    // read the stage memory
    logic mul_fwd;   // multiply coefficient by stage input
    logic sum_y;     // form the stage output
    logic mul_back;  // multiply coefficient by stage output
    logic mem_wr;    // write the new stage memory and advance the stage
    logic finish;    // mix, saturate, register the result, advance the phase
  } lph_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic last_stage;   // current stage is the final allpass section
    logic out_blocked;  // output register holds a result that is not taken
  } lph_status_t;

  // Restoring long division, used only while the coefficient table is built
  function automatic logic [63:0] udiv64(input logic [63:0] dividend,
                                         input logic [63:0] divisor);
    logic [64:0] part;
    logic [63:0] quo;
    int b;
    part = '0;
    quo  = '0;
    for (b = 63; b >= 0; b--) begin
      part = {part[63:0], dividend[b]};
      if (part >= {1'b0, divisor}) begin
        part   = part - {1'b0, divisor};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Truncating Taylor series in Q30: odd selects sine, else cosine
  function automatic logic [63:0] series_q30(input logic [63:0] x, input logic odd);
    logic [63:0] term;
    logic [63:0] k;
    logic [63:0] sum;
    int n;
    term = odd ? x : Q30_ONE;
    k    = odd ? 64'd1 : 64'd0;
    sum  = term;
    for (n = 0; n < 10; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = udiv64(term, (k + 64'd1) * (k + 64'd2));
      k    = k + 64'd2;
      if (n[0]) begin
        sum = sum + term;
      end else begin
        sum = sum - term;
      end
    end
    return sum;
  endfunction

  // One Q1.15 allpass coefficient for LFO table position k
  function automatic logic [COEFF_W-1:0] coeff_entry(input int k);
    logic [63:0] q4;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] ang;
    longint      sv;
    longint      cv;
    longint      lfo;
    longint      freq;
    logic [63:0] ratio;
    logic [63:0] w;
    longint      s;
    longint      c;
    longint      num;
    longint      den;
    logic [63:0] mag;
    logic [63:0] q;
    longint      res;
    q4   = 64'(4 * k);
    quad = q4 / 64'(COEFF_TABLE_DEPTH);
    rem  = q4 % 64'(COEFF_TABLE_DEPTH);
    ang  = (PI_Q30 * rem) / 64'(2 * COEFF_TABLE_DEPTH);
    sv   = signed'(series_q30(ang, 1'b1));
    cv   = signed'(series_q30(ang, 1'b0));
    if (quad == 64'd0) begin
      lfo = sv;
    end else if (quad == 64'd1) begin
      lfo = cv;
    end else if (quad == 64'd2) begin
      lfo = -sv;
    end else begin
      lfo = -cv;
    end
    freq = 64'sd1000 * signed'(Q30_ONE) + 64'sd500 * lfo;
    if (freq < 0) begin
      freq = 0;
    end
    ratio = unsigned'(freq) / 64'(SAMPLE_RATE);
    w     = (ratio * PI_Q30) >> 30;
    s     = signed'(series_q30(w, 1'b1));
    c     = signed'(series_q30(w, 1'b0));
    num   = s - c;
    den   = s + c;
    if (den <= 0) begin
      den = 1;
    end
    mag = unsigned'(num < 0 ? -num : num) << 15;
    q   = udiv64(mag + (unsigned'(den) >> 1), unsigned'(den));
    if (q > 64'd32768) begin
      q = 64'd32768;
    end
    res = (num < 0) ? -signed'(q) : signed'(q);
    if (res > 32767) begin
      res = 32767;
    end
    return res[COEFF_W-1:0];
  endfunction

  // Pack the whole coefficient table, entry k at bits [k*COEFF_W +: COEFF_W]
  function automatic logic [COEFF_TABLE_DEPTH*COEFF_W-1:0] build_coeff_rom();
    logic [COEFF_TABLE_DEPTH*COEFF_W-1:0] rom;
    int i;
    rom = '0;
    for (i = 0; i < COEFF_TABLE_DEPTH; i++) begin
      rom[i*COEFF_W +: COEFF_W] = coeff_entry(i);
    end
    return rom;
  endfunction

  localparam logic [COEFF_TABLE_DEPTH*COEFF_W-1:0] COEFF_ROM = build_coeff_rom();

  // Constant table lookup
  function automatic logic signed [COEFF_W-1:0] coeff_at(input logic [COEFF_IDX_W-1:0] idx);
    return signed'(COEFF_ROM[int'(idx)*COEFF_W +: COEFF_W]);
  endfunction

endpackage

// ----- sv/lph_ram.sv -----
module lph_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lph_ctrl.sv -----
module lph_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lph_pkg::lph_status_t status_i,
  output lph_pkg::lph_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_FWD,
    ST_SUM_Y,
    ST_MUL_BACK,
    ST_WRITE,
    ST_FINISH
  } state_e;

  state_e state_q;

  // Advance through the allpass sections, one memory read and two products each
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_READ;
          end
        end
        ST_READ:     state_q <= ST_MUL_FWD;
        ST_MUL_FWD:  state_q <= ST_SUM_Y;
        ST_SUM_Y:    state_q <= ST_MUL_BACK;
        ST_MUL_BACK: state_q <= ST_WRITE;
        ST_WRITE: begin
          state_q <= status_i.last_stage ? ST_FINISH : ST_READ;
        end
        ST_FINISH: begin
          if (!status_i.out_blocked) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Decode datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mem_rd   = (state_q == ST_READ);
    cmd_o.mul_fwd  = (state_q == ST_MUL_FWD);
    cmd_o.sum_y    = (state_q == ST_SUM_Y);
    cmd_o.mul_back = (state_q == ST_MUL_BACK);
    cmd_o.mem_wr   = (state_q == ST_WRITE);
    cmd_o.finish   = (state_q == ST_FINISH) && !status_i.out_blocked;
  end

endmodule

// ----- sv/lph_dp.sv -----
module lph_dp #(
  parameter int CHANNELS = 2,
  parameter int STAGES   = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lph_pkg::lph_cmd_t                    cmd_i,
  output lph_pkg::lph_status_t                 status_o,
  input  logic signed [lph_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic                                 channel_i,
  input  logic                                 cfg_valid_i,
  input  logic [lph_pkg::STEP_W-1:0]           cfg_phase_step_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [lph_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic                                 channel_out_o
);

  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW     = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int ZDEPTH = CHANNELS * STAGES;
  localparam int AW     = (ZDEPTH > 1) ? $clog2(ZDEPTH) : 1;
  localparam int MW     = lph_pkg::MEM_W;
  localparam int RW     = lph_pkg::PROD_W + 1 - 15;

  localparam logic signed [MW+2:0] MEM_MAX = (MW+3)'((1 << (MW - 1)) - 1);
  localparam logic signed [MW+2:0] MEM_MIN = -(MW+3)'(1 << (MW - 1));
  localparam logic signed [MW:0]   OUT_MAX = (MW+1)'((1 << (lph_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [MW:0]   OUT_MIN = -(MW+1)'(1 << (lph_pkg::SAMPLE_W - 1));

  function automatic logic signed [MW-1:0] sat_mem(input logic signed [MW+2:0] a);
    logic signed [MW+2:0] r;
    r = (a > MEM_MAX) ? MEM_MAX : (a < MEM_MIN) ? MEM_MIN : a;
    return r[MW-1:0];
  endfunction

  function automatic logic signed [lph_pkg::SAMPLE_W-1:0] sat_out(input logic signed [MW:0] a);
    logic signed [MW:0] r;
    r = (a > OUT_MAX) ? OUT_MAX : (a < OUT_MIN) ? OUT_MIN : a;
    return r[lph_pkg::SAMPLE_W-1:0];
  endfunction

  // Per-channel state and working registers
  logic [lph_pkg::PHASE_W-1:0]          lfo_phase_q [CHANNELS];
  logic [lph_pkg::STEP_W-1:0]           step_q;
  logic [ZDEPTH-1:0]                    zvalid_q;
  logic                                 rvalid_q;
  logic [CW-1:0]                        ch_q;
  logic                                 chan_bit_q;
  logic [SW-1:0]                        stage_q;
  logic signed [lph_pkg::SAMPLE_W-1:0]  dry_q;
  logic signed [lph_pkg::COEFF_W-1:0]   coef_q;
  logic signed [MW-1:0]                 v_q;
  logic signed [MW-1:0]                 y_q;
  logic signed [MW-1:0]                 z_q;
  logic signed [lph_pkg::PROD_W-1:0]    prod_q;
  logic                                 out_valid_q;
  logic signed [lph_pkg::SAMPLE_W-1:0]  out_data_q;
  logic                                 out_chan_q;

  logic [CW-1:0]                        ch_in;
  logic [lph_pkg::PHASE_W-1:0]          phase_in;
  logic [AW-1:0]                        zaddr;
  logic [MW-1:0]                        zrdata;
  logic signed [MW-1:0]                 mul_b;
  logic signed [lph_pkg::PROD_W:0]      rnd_sum;
  logic signed [RW-1:0]                 rnd;
  logic signed [MW+2:0]                 y_sum;
  logic signed [MW+2:0]                 z_diff;
  logic signed [MW-1:0]                 y_d;
  logic signed [MW-1:0]                 z_d;
  logic signed [MW:0]                   mix_sum;
  logic signed [MW:0]                   mix_half;

  // Channel number folds onto the configured channel count
  assign ch_in    = (CHANNELS > 1) ? CW'(channel_i) : '0;
  assign phase_in = lfo_phase_q[ch_in];
  assign zaddr    = AW'(int'(ch_q) * STAGES + int'(stage_q));

  // Shared multiplier operand and Q15 rounding of the product
  assign mul_b   = cmd_i.mul_back ? y_q : v_q;
  assign rnd_sum = (lph_pkg::PROD_W+1)'(prod_q) + (lph_pkg::PROD_W+1)'(16384);
  assign rnd     = RW'(rnd_sum >>> 15);
  assign y_sum   = (MW+3)'(rnd) + (MW+3)'(z_q);
  assign z_diff  = (MW+3)'(v_q) - (MW+3)'(rnd);
  assign y_d     = sat_mem(y_sum);
  assign z_d     = sat_mem(z_diff);

  // Dry/wet mix with floor halving
  assign mix_sum  = (MW+1)'(dry_q) + (MW+1)'(v_q);
  assign mix_half = mix_sum >>> 1;

  lph_ram #(
    .WIDTH (MW),
    .DEPTH (ZDEPTH)
  ) u_zmem (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_wr),
    .waddr_i (zaddr),
    .wdata_i (z_d),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (zaddr),
    .rdata_o (zrdata)
  );

  // Control state: phases, step, memory valid bits, stage counter, output flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lfo_phase_q[i] <= '0;
      end
      step_q      <= lph_pkg::PHASE_STEP_RESET;
      zvalid_q    <= '0;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        step_q <= cfg_phase_step_i;
      end
      if (cmd_i.load) begin
        stage_q <= '0;
      end
      if (cmd_i.mem_wr) begin
        zvalid_q[zaddr] <= 1'b1;
        stage_q         <= stage_q + SW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q       <= 1'b1;
        lfo_phase_q[ch_q] <= lfo_phase_q[ch_q] + lph_pkg::PHASE_W'(step_q);
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dry_q      <= sample_in_i;
      v_q        <= MW'(sample_in_i);
      ch_q       <= ch_in;
      chan_bit_q <= channel_i;
      coef_q     <= lph_pkg::coeff_at(
                      phase_in[lph_pkg::PHASE_W-1 -: lph_pkg::COEFF_IDX_W]);
    end
    if (cmd_i.mem_rd) begin
      rvalid_q <= zvalid_q[zaddr];
    end
    if (cmd_i.mul_fwd) begin
      z_q <= rvalid_q ? signed'(zrdata) : '0;
    end
    if (cmd_i.mul_fwd || cmd_i.mul_back) begin
      prod_q <= lph_pkg::PROD_W'(coef_q) * lph_pkg::PROD_W'(mul_b);
    end
    if (cmd_i.sum_y) begin
      y_q <= y_d;
    end
    if (cmd_i.mem_wr) begin
      v_q <= y_q;
    end
    if (cmd_i.finish) begin
      out_data_q <= sat_out(mix_half);
      out_chan_q <= chan_bit_q;
    end
  end

  assign status_o.last_stage  = (stage_q == SW'(STAGES - 1));
  assign status_o.out_blocked = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_data_q;
  assign channel_out_o = out_chan_q;

endmodule

// ----- sv/four_stage_lfo_phaser.sv -----
// Four-section allpass phaser with a per-channel sine LFO.
// Input channel: sample_in_i (Q1.15) and channel_i, accepted when in_valid_i
// and in_ready_o are both high. Output channel: sample_out_o (Q1.15, half dry
// plus half allpassed, saturated) and channel_out_o, taken when out_valid_o
// and out_ready_i are both high. The phase step register is written through
// cfg_valid_i/cfg_phase_step_i; cfg_ready_o is always high.
// One transaction is processed at a time. Each allpass section steps
// through a memory read, the forward product, the sum, the back product
// and the write back, both products on one shared multiplier. A new
// transaction is taken only once the last section has finished and its
// result is registered. The next transaction may be accepted while the
// previous result still waits in the output register; if the receiver
// stalls, the block holds in its final step until that register is free.
// Reset clears the LFO phases, sets the phase step to 350 and marks every
// allpass memory as zero through valid bits; no clearing pass is needed and
// the block is ready as soon as reset is released.
module four_stage_lfo_phaser #(
  parameter int CHANNELS = 2,
  parameter int STAGES   = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [lph_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic                                 channel_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [lph_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic                                 channel_out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lph_pkg::STEP_W-1:0]           cfg_phase_step_i
);

  lph_pkg::lph_cmd_t    cmd;
  lph_pkg::lph_status_t status;

  assign cfg_ready_o = 1'b1;

  lph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lph_dp #(
    .CHANNELS (CHANNELS),
    .STAGES   (STAGES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .sample_in_i      (sample_in_i),
    .channel_i        (channel_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_phase_step_i (cfg_phase_step_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .sample_out_o     (sample_out_o),
    .channel_out_o    (channel_out_o)
  );

  // Ready drops once a transaction is accepted
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o
  ) else $error("input accepted again while a transaction is in flight");

  // A new result only appears while a transaction is being processed
  a_result_from_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o)
  ) else $error("result produced without a transaction in flight");

  // Accepting input leaves a waiting result untouched
  a_accept_keeps_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o || $stable(sample_out_o)
  ) else $error("waiting result disturbed by an accepted transaction");

endmodule
